/* design/ttf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types and constants of the tachometer telemetry framer.
// ----------------------------------------------------------------------------
package ttf_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUMERATOR   = 1'b1;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  REPORT_INTERVAL_RST = 8'd10;
    localparam logic [15:0] RPM_NUMERATOR_RST   = 16'd60000;
    localparam logic [15:0] ZERO_INTERVAL_RPM   = 16'd60000;
    localparam logic [15:0] SHOWN_RPM_MAX       = 16'd9999;

    localparam int QUO_W    = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 4'd15;

    // Frame layout.
    localparam int BYTE_IDX_W = 4;
    localparam logic [BYTE_IDX_W-1:0] BYTE_T    = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_P    = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST = 4'd9;

    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    localparam int WORK_W = 14;
    localparam logic [WORK_W-1:0] DIGIT_WEIGHT [4] = '{14'd1000, 14'd100, 14'd10, 14'd1};

    typedef struct packed {
        logic [31:0] now_ms;
        logic        hall_level;
        logic [11:0] adc_sample;
        logic        adc_valid;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_STORE,
        S_COUNT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  capture;
        logic                  calc;
        logic                  div_step;
        logic                  div_store;
        logic                  cnt_inc;
        logic                  cnt_clr;
        logic                  out_load;
        logic [BYTE_IDX_W-1:0] byte_idx;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic count_match;
        logic out_free;
    } t_status;

endpackage

/* design/tachometer_telemetry_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tachometer_telemetry_framer
// Period-based tachometer that reports ADC and RPM as a ten-byte ASCII frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one sample per transaction (timestamp, hall level,
// ADC value and its valid flag). The output channel delivers frame bytes, one
// per transaction, with frame_last on the tenth byte. Every report_interval+1
// samples a frame "T dddd P dddd" (no spaces) follows the sample.
// Timing: a high hall sample with a nonzero interval runs a 16-step restoring
// divider between the update and the counter check; a low sample, or a high
// one with a zero interval, goes straight from the update to the check. A frame
// adds its ten bytes, one byte per cycle while the receiver takes them.
// The divider's one quotient bit per cycle sets the per-sample latency.
// One sample is in flight at a time; the next is accepted once the last
// byte sits in the output register.
// Receiver stall: the byte in the output register holds and the sequencer
// waits; nothing is lost. Reset (synchronous, active low) clears the state
// and restores report_interval to 10 and rpm_numerator to 60000.
// Configuration writes are taken at once through the write port.
// ----------------------------------------------------------------------------
module tachometer_telemetry_framer #(
    parameter int TICK_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ttf_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ttf_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ttf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ttf_pkg::t_cmd    cmd;
    ttf_pkg::t_status status;

    ttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ttf_dp #(
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

/* design/ttf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_ctrl
// Sequencer: sample update, serial divide, counter check and frame emission.
// ----------------------------------------------------------------------------
module ttf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ttf_pkg::t_status i_status,
    output ttf_pkg::t_cmd    o_cmd
);

    ttf_pkg::t_state r_state, n_state;
    logic [ttf_pkg::DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [ttf_pkg::BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttf_pkg::S_IDLE;
            r_div_cnt  <= '0;
            r_byte_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_div_cnt  <= n_div_cnt;
            r_byte_idx <= n_byte_idx;
        end
    end

    // Next state and counters.
    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        n_byte_idx = r_byte_idx;
        unique case (r_state)
            ttf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttf_pkg::S_CALC;
                end
            end
            ttf_pkg::S_CALC: begin
                n_div_cnt = '0;
                n_state   = i_status.div_needed ? ttf_pkg::S_DIV : ttf_pkg::S_COUNT;
            end
            ttf_pkg::S_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == ttf_pkg::DIV_LAST_STEP) begin
                    n_state = ttf_pkg::S_STORE;
                end
            end
            ttf_pkg::S_STORE: begin
                n_state = ttf_pkg::S_COUNT;
            end
            ttf_pkg::S_COUNT: begin
                n_byte_idx = ttf_pkg::BYTE_T;
                n_state    = i_status.count_match ? ttf_pkg::S_EMIT : ttf_pkg::S_IDLE;
            end
            ttf_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_byte_idx = r_byte_idx + 1'b1;
                    if (r_byte_idx == ttf_pkg::BYTE_LAST) begin
                        n_state = ttf_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = ttf_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.byte_idx = r_byte_idx;
        unique case (r_state)
            ttf_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ttf_pkg::S_CALC:  o_cmd.calc      = 1'b1;
            ttf_pkg::S_DIV:   o_cmd.div_step  = 1'b1;
            ttf_pkg::S_STORE: o_cmd.div_store = 1'b1;
            ttf_pkg::S_COUNT: begin
                o_cmd.cnt_inc = !i_status.count_match;
                o_cmd.cnt_clr = i_status.count_match;
            end
            ttf_pkg::S_EMIT:  o_cmd.out_load  = i_status.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

/* design/ttf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_dp
// Datapath: sample state, restoring divider, digit extraction, output register.
// ----------------------------------------------------------------------------
module ttf_dp #(
    parameter int TICK_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ttf_pkg::t_in_item               i_in_data,
    output ttf_pkg::t_out_item              o_out_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_cfg_we,
    input  logic [ttf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  ttf_pkg::t_cmd                   i_cmd,
    output ttf_pkg::t_status                o_status
);

    localparam int QW = ttf_pkg::QUO_W;
    localparam int WW = ttf_pkg::WORK_W;

    logic [7:0]           r_report_interval;
    logic [15:0]          r_rpm_numerator;
    logic [TICK_BITS-1:0] r_now;
    logic                 r_hall;
    logic [TICK_BITS-1:0] r_last_event;
    logic [15:0]          r_rpm;
    logic [11:0]          r_adc_last;
    logic [7:0]           r_sample_count;
    logic [TICK_BITS-1:0] r_rem;
    logic [QW-1:0]        r_quo;
    logic [TICK_BITS-1:0] r_div;
    logic [WW-1:0]        r_work;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [TICK_BITS-1:0] elapsed;
    logic [TICK_BITS:0]   trial;
    logic                 trial_ge;
    logic [WW-1:0]        shown;
    logic [3:0]           dig [4];
    logic [1:0]           pos;
    logic [3:0]           dig_sel;
    logic                 is_digit;
    logic [7:0]           n_byte;

    assign elapsed  = r_now - r_last_event;
    assign trial    = {r_rem, r_quo[QW-1]};
    assign trial_ge = trial >= {1'b0, r_div};
    assign shown    = (r_rpm > ttf_pkg::SHOWN_RPM_MAX) ? WW'(ttf_pkg::SHOWN_RPM_MAX)
                                                       : WW'(r_rpm);

    // Each decimal digit is found by comparing against the nine multiples of its weight.
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            dig[p] = '0;
            for (int k = 1; k < 10; k++) begin
                if (r_work >= WW'(ttf_pkg::DIGIT_WEIGHT[p] * WW'(k))) begin
                    dig[p] = 4'(k);
                end
            end
        end
    end

    always_comb begin
        pos      = '0;
        is_digit = 1'b1;
        case (i_cmd.byte_idx)
            4'd1, 4'd6: pos = 2'd0;
            4'd2, 4'd7: pos = 2'd1;
            4'd3, 4'd8: pos = 2'd2;
            4'd4, 4'd9: pos = 2'd3;
            default:    is_digit = 1'b0;
        endcase
        dig_sel = dig[pos];
        if (i_cmd.byte_idx == ttf_pkg::BYTE_T) begin
            n_byte = ttf_pkg::CHAR_T;
        end else if (i_cmd.byte_idx == ttf_pkg::BYTE_P) begin
            n_byte = ttf_pkg::CHAR_P;
        end else begin
            n_byte = ttf_pkg::CHAR_ZERO + {4'd0, dig_sel};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_interval <= ttf_pkg::REPORT_INTERVAL_RST;
            r_rpm_numerator   <= ttf_pkg::RPM_NUMERATOR_RST;
            r_last_event      <= '0;
            r_rpm             <= '0;
            r_adc_last        <= '0;
            r_sample_count    <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ttf_pkg::CFG_REPORT_INTERVAL: r_report_interval <= i_cfg_data[7:0];
                    ttf_pkg::CFG_RPM_NUMERATOR:   r_rpm_numerator   <= i_cfg_data;
                    default: r_rpm_numerator <= r_rpm_numerator;
                endcase
            end
            if (i_cmd.capture && i_in_data.adc_valid) begin
                r_adc_last <= i_in_data.adc_sample;
            end
            if (i_cmd.calc) begin
                if (r_hall) begin
                    r_last_event <= r_now;
                    if (elapsed == '0) begin
                        r_rpm <= ttf_pkg::ZERO_INTERVAL_RPM;
                    end
                end else if (r_rpm != '0) begin
                    r_rpm <= r_rpm - 1'b1;
                end
            end
            if (i_cmd.div_store) begin
                r_rpm <= r_quo;
            end
            if (i_cmd.cnt_inc) begin
                r_sample_count <= r_sample_count + 1'b1;
            end else if (i_cmd.cnt_clr) begin
                r_sample_count <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now  <= i_in_data.now_ms[TICK_BITS-1:0];
            r_hall <= i_in_data.hall_level;
        end
        if (i_cmd.calc) begin
            r_rem <= '0;
            r_quo <= r_rpm_numerator;
            r_div <= elapsed;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? TICK_BITS'(trial - {1'b0, r_div}) : trial[TICK_BITS-1:0];
            r_quo <= {r_quo[QW-2:0], trial_ge};
        end
        if (i_cmd.out_load) begin
            r_out_byte <= n_byte;
            r_out_last <= (i_cmd.byte_idx == ttf_pkg::BYTE_LAST);
            // The working value holds what is left to print of the current number.
            if (i_cmd.byte_idx == ttf_pkg::BYTE_T) begin
                r_work <= WW'(r_adc_last);
            end else if (i_cmd.byte_idx == ttf_pkg::BYTE_P) begin
                r_work <= shown;
            end else if (is_digit) begin
                r_work <= r_work - WW'(dig_sel) * ttf_pkg::DIGIT_WEIGHT[pos];
            end
        end
    end

    assign o_status.div_needed  = r_hall && (elapsed != '0);
    assign o_status.count_match = (r_sample_count == r_report_interval);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_out_data.frame_byte = r_out_byte;
    assign o_out_data.frame_last = r_out_last;

endmodule
